[src/bsd_pkg.sv]
// ----------------------------------------------------------------------------
// bsd_pkg - shared types and constants for the BOM sniffing text decoder
// Payload structs, queue entry format, byte-order-mark and UTF-8 lead codes.
// ----------------------------------------------------------------------------
package bsd_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic        end_of_text;
      logic [1:0]  encoding;
      logic        truncated;
   } rsp_payload_type;

   // what the back end does with a queue entry
   typedef enum logic [1:0] {
      OP_UTF8,
      OP_UTF16,
      OP_END
   } op_kind_type;

   // stream form as fixed by the mark
   typedef enum logic [1:0] {
      MODE_UTF8,
      MODE_LE,
      MODE_BE
   } text_mode_type;

   typedef struct packed {
      op_kind_type   kind;
      text_mode_type mode;
      logic [7:0]    data;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // reported encoding codes
   localparam logic [1:0] ENC_UTF8    = 2'd0;
   localparam logic [1:0] ENC_NATIVE  = 2'd1;
   localparam logic [1:0] ENC_SWAPPED = 2'd2;

   // ops one input byte can give: up to three replayed bytes plus end marker
   localparam int PLAN_SLOTS = 4;

   // byte-order marks
   localparam logic [7:0] BOM_FF = 8'hFF;
   localparam logic [7:0] BOM_FE = 8'hFE;
   localparam logic [7:0] BOM_EF = 8'hEF;
   localparam logic [7:0] BOM_BB = 8'hBB;
   localparam logic [7:0] BOM_BF = 8'hBF;

   // UTF-8 lead byte masks and patterns
   localparam logic [7:0] ASCII_MASK = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_PAT  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_PAT  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_PAT  = 8'hF0;
   localparam logic [7:0] LEAD5_MASK = 8'hFC;
   localparam logic [7:0] LEAD5_PAT  = 8'hF8;
   localparam logic [7:0] LEAD6_MASK = 8'hFE;
   localparam logic [7:0] LEAD6_PAT  = 8'hFC;
   localparam logic [7:0] CONT_MASK  = 8'h3F;

   function automatic logic [1:0] encoding_of(text_mode_type mode, logic host_le);
      logic [1:0] enc;
      case (mode)
         MODE_LE: enc = host_le ? ENC_NATIVE : ENC_SWAPPED;
         MODE_BE: enc = host_le ? ENC_SWAPPED : ENC_NATIVE;
         default: enc = ENC_UTF8;
      endcase
      return enc;
   endfunction

endpackage

[src/bsd_fifo.sv]
// ----------------------------------------------------------------------------
// bsd_fifo - short operation queue between front and back end
// First-word fall-through; push ignored when full, pop ignored when empty.
// ----------------------------------------------------------------------------
module bsd_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bsd_pkg::op_type           push_op,
   input  logic                      pop,
   output bsd_pkg::op_type           head_op,
   output bsd_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bsd_pkg::op_type  mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign status.full  = (cnt_ff == FULL_CNT);
   assign status.empty = (cnt_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[src/bsd_front.sv]
// ----------------------------------------------------------------------------
// bsd_front - byte intake and mark sniffing
// Holds the opening bytes, picks the stream form and issues queue operations.
// ----------------------------------------------------------------------------
module bsd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  bsd_pkg::req_payload_type  req_payload,
   output logic                      q_push,
   output bsd_pkg::op_type           q_op,
   input  bsd_pkg::queue_status_type q_status
);

   typedef enum logic [1:0] {
      PH_SNIFF,
      PH_UTF8,
      PH_LE,
      PH_BE
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [1:0]           held_cnt_ff, held_cnt_in;
   logic [7:0]           held0_ff, held0_in;
   logic [7:0]           held1_ff, held1_in;
   bsd_pkg::op_type      plan_ff [bsd_pkg::PLAN_SLOTS];
   bsd_pkg::op_type      plan_in [bsd_pkg::PLAN_SLOTS];
   logic [2:0]           plan_cnt_ff, plan_cnt_in;

   logic                  accept, push_done;
   logic [7:0]            b;
   logic                  last;
   logic [1:0]            n_data;
   logic [7:0]            dat [bsd_pkg::PLAN_SLOTS];
   bsd_pkg::op_kind_type  data_kind;
   bsd_pkg::text_mode_type mode;

   assign b         = req_payload.data_byte;
   assign last      = req_payload.last_byte;
   assign push_done = (plan_cnt_ff != 3'd0) && !q_status.full;
   assign req_stall = !((plan_cnt_ff == 3'd0) || ((plan_cnt_ff == 3'd1) && !q_status.full));
   assign accept    = req_valid && !req_stall;
   assign q_push    = (plan_cnt_ff != 3'd0);
   assign q_op      = plan_ff[0];

   always_comb begin
      phase_in    = phase_ff;
      held_cnt_in = held_cnt_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      n_data      = 2'd0;
      dat[0]      = b;
      dat[1]      = 8'h00;
      dat[2]      = 8'h00;
      dat[3]      = 8'h00;
      data_kind   = bsd_pkg::OP_UTF8;
      mode        = bsd_pkg::MODE_UTF8;

      case (phase_ff)
         PH_SNIFF: begin
            case (held_cnt_ff)
               2'd0: begin
                  held0_in    = b;
                  held_cnt_in = 2'd1;
                  if (last) begin
                     n_data = 2'd1;
                  end
               end
               2'd1: begin
                  if (held0_ff == bsd_pkg::BOM_FF && b == bsd_pkg::BOM_FE) begin
                     phase_in    = PH_LE;
                     held_cnt_in = 2'd0;
                     mode        = bsd_pkg::MODE_LE;
                  end else if (held0_ff == bsd_pkg::BOM_FE && b == bsd_pkg::BOM_FF) begin
                     phase_in    = PH_BE;
                     held_cnt_in = 2'd0;
                     mode        = bsd_pkg::MODE_BE;
                  end else if (!(held0_ff == bsd_pkg::BOM_EF && b == bsd_pkg::BOM_BB)
                               || last) begin
                     // not a mark: replay both bytes as UTF-8
                     n_data      = 2'd2;
                     dat[0]      = held0_ff;
                     dat[1]      = b;
                     phase_in    = PH_UTF8;
                     held_cnt_in = 2'd0;
                  end else begin
                     held1_in    = b;
                     held_cnt_in = 2'd2;
                  end
               end
               default: begin
                  phase_in    = PH_UTF8;
                  held_cnt_in = 2'd0;
                  if (b != bsd_pkg::BOM_BF) begin
                     n_data = 2'd3;
                     dat[0] = held0_ff;
                     dat[1] = held1_ff;
                     dat[2] = b;
                  end
               end
            endcase
         end
         PH_UTF8: begin
            n_data = 2'd1;
         end
         PH_LE: begin
            n_data    = 2'd1;
            data_kind = bsd_pkg::OP_UTF16;
            mode      = bsd_pkg::MODE_LE;
         end
         PH_BE: begin
            n_data    = 2'd1;
            data_kind = bsd_pkg::OP_UTF16;
            mode      = bsd_pkg::MODE_BE;
         end
         default: begin
            n_data = 2'd0;
         end
      endcase

      // end of buffer: start over with a fresh sniff
      if (last) begin
         phase_in    = PH_SNIFF;
         held_cnt_in = 2'd0;
      end

      if (accept) begin
         for (int i = 0; i < bsd_pkg::PLAN_SLOTS; i++) begin
            if (3'(i) < {1'b0, n_data}) begin
               plan_in[i].kind = data_kind;
               plan_in[i].data = dat[i];
            end else begin
               plan_in[i].kind = bsd_pkg::OP_END;
               plan_in[i].data = 8'h00;
            end
            plan_in[i].mode = mode;
         end
         plan_cnt_in = {1'b0, n_data} + {2'b00, last};
      end else if (push_done) begin
         for (int i = 0; i < bsd_pkg::PLAN_SLOTS - 1; i++) begin
            plan_in[i] = plan_ff[i+1];
         end
         plan_in[bsd_pkg::PLAN_SLOTS-1] = plan_ff[bsd_pkg::PLAN_SLOTS-1];
         plan_cnt_in = plan_cnt_ff - 3'd1;
      end else begin
         for (int i = 0; i < bsd_pkg::PLAN_SLOTS; i++) begin
            plan_in[i] = plan_ff[i];
         end
         plan_cnt_in = plan_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
      if (accept) begin
         held0_ff <= held0_in;
         held1_ff <= held1_in;
      end
      if (reset) begin
         phase_ff    <= PH_SNIFF;
         held_cnt_ff <= 2'd0;
         plan_cnt_ff <= 3'd0;
      end else begin
         if (accept) begin
            phase_ff    <= phase_in;
            held_cnt_ff <= held_cnt_in;
         end
         plan_cnt_ff <= plan_cnt_in;
      end
   end

endmodule

[src/bsd_back.sv]
// ----------------------------------------------------------------------------
// bsd_back - UTF-8 decode and UTF-16 pairing
// Executes queued operations and drives the registered result channel.
// ----------------------------------------------------------------------------
module bsd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      host_le,
   input  bsd_pkg::op_type           head_op,
   input  bsd_pkg::queue_status_type q_status,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output bsd_pkg::rsp_payload_type  rsp_payload
);

   logic [2:0]  rem_ff, rem_in;
   logic [15:0] acc_ff, acc_in;
   logic        stop_ff, stop_in;
   logic        pend_v_ff, pend_v_in;
   logic [7:0]  pend_ff, pend_in;
   logic        rsp_valid_ff;
   bsd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic        out_free, emit;
   logic [15:0] acc_sh;
   logic [7:0]  b;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = out_free && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign b      = head_op.data;
   assign acc_sh = {acc_ff[9:0], b[5:0]};

   always_comb begin
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      stop_in   = stop_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      emit      = 1'b0;
      rsp_payload_in.code_unit   = 16'h0000;
      rsp_payload_in.unit_valid  = 1'b1;
      rsp_payload_in.end_of_text = 1'b0;
      rsp_payload_in.encoding    = bsd_pkg::encoding_of(head_op.mode, host_le);
      rsp_payload_in.truncated   = 1'b0;

      if (q_pop) begin
         case (head_op.kind)
            bsd_pkg::OP_UTF8: begin
               if (!stop_ff) begin
                  if (rem_ff != 3'd0) begin
                     acc_in = acc_sh;
                     rem_in = rem_ff - 3'd1;
                     if (rem_ff == 3'd1) begin
                        emit = 1'b1;
                        rsp_payload_in.code_unit = acc_sh;
                        if (acc_sh == 16'h0000) begin
                           stop_in = 1'b1;
                        end
                     end
                  end else if ((b & bsd_pkg::ASCII_MASK) == 8'h00) begin
                     emit = 1'b1;
                     rsp_payload_in.code_unit = {8'h00, b};
                     if (b == 8'h00) begin
                        stop_in = 1'b1;
                     end
                  end else if ((b & bsd_pkg::LEAD2_MASK) == bsd_pkg::LEAD2_PAT) begin
                     acc_in = {11'd0, b[4:0]};
                     rem_in = 3'd1;
                  end else if ((b & bsd_pkg::LEAD3_MASK) == bsd_pkg::LEAD3_PAT) begin
                     acc_in = {12'd0, b[3:0]};
                     rem_in = 3'd2;
                  end else if ((b & bsd_pkg::LEAD4_MASK) == bsd_pkg::LEAD4_PAT) begin
                     acc_in = {13'd0, b[2:0]};
                     rem_in = 3'd3;
                  end else if ((b & bsd_pkg::LEAD5_MASK) == bsd_pkg::LEAD5_PAT) begin
                     acc_in = {14'd0, b[1:0]};
                     rem_in = 3'd4;
                  end else if ((b & bsd_pkg::LEAD6_MASK) == bsd_pkg::LEAD6_PAT) begin
                     acc_in = {15'd0, b[0]};
                     rem_in = 3'd5;
                  end else begin
                     // stray continuation or FE/FF: zero unit, decoding stops
                     emit    = 1'b1;
                     stop_in = 1'b1;
                  end
               end
            end
            bsd_pkg::OP_UTF16: begin
               if (pend_v_ff) begin
                  emit      = 1'b1;
                  pend_v_in = 1'b0;
                  rsp_payload_in.code_unit = (head_op.mode == bsd_pkg::MODE_LE) ?
                                             {b, pend_ff} : {pend_ff, b};
               end else begin
                  pend_v_in = 1'b1;
                  pend_in   = b;
               end
            end
            bsd_pkg::OP_END: begin
               emit = 1'b1;
               rsp_payload_in.unit_valid  = 1'b0;
               rsp_payload_in.end_of_text = 1'b1;
               rsp_payload_in.truncated   = (head_op.mode == bsd_pkg::MODE_UTF8)
                                            && (rem_ff != 3'd0) && !stop_ff;
               rem_in    = 3'd0;
               acc_in    = 16'h0000;
               stop_in   = 1'b0;
               pend_v_in = 1'b0;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      pend_ff <= pend_in;
      if (out_free) begin
         rsp_payload_ff <= rsp_payload_in;
      end
      if (reset) begin
         rem_ff       <= 3'd0;
         stop_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rem_ff    <= rem_in;
         stop_ff   <= stop_in;
         pend_v_ff <= pend_v_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
   end

endmodule

[src/bom_sniffing_text_decoder.sv]
// ----------------------------------------------------------------------------
// bom_sniffing_text_decoder - byte stream to 16-bit code units
// Sniffs a byte-order mark, then decodes UTF-16 (either order) or UTF-8.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* takes one text byte per transaction; last_byte closes the buffer.
//  - rsp_* gives code units, and one end-of-text transaction after the last
//    byte carrying the detected encoding and the truncation flag.
//  - csr_wr_en/csr_wr_data set host byte order (1 = little-endian); write
//    it only while the block is idle.
//  - Throughput: one byte per cycle while the operation plan register holds
//    no more than one pending op and the queue is not full; replayed opening
//    bytes and the end transaction drain from that register first.
//  - A result reaches rsp through the plan register, the queue and then
//    the result register.
//  - rsp_stall holds the result register; the queue of QUEUE_DEPTH ops
//    absorbs intake until full, then req_stall rises.
//  - Reset (synchronous): empty queue, sniffing, host order little-endian.
// ----------------------------------------------------------------------------
module bom_sniffing_text_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bsd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output bsd_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic                     csr_wr_data
);

   logic                      host_le_ff;
   logic                      q_push, q_pop;
   bsd_pkg::op_type           q_op, head_op;
   bsd_pkg::queue_status_type q_status;

   // host byte order register
   always_ff @(posedge clock) begin
      if (reset) begin
         host_le_ff <= 1'b1;
      end else if (csr_wr_en) begin
         host_le_ff <= csr_wr_data;
      end
   end

   // front end: intake, mark sniffing, operation issue
   bsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_push      (q_push),
      .q_op        (q_op),
      .q_status    (q_status)
   );

   // decoupling queue
   bsd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (q_op),
      .pop     (q_pop),
      .head_op (head_op),
      .status  (q_status)
   );

   // back end: decode and result register
   bsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .host_le     (host_le_ff),
      .head_op     (head_op),
      .q_status    (q_status),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb - testbench for bom_sniffing_text_decoder
// Feeds text buffers one byte per transaction: a short directed table of
// marks, short buffers and odd sequences, then random buffers (UTF-8 with and
// without mark, UTF-16 in both orders, broken and noisy ones) under each host
// byte order. Every result is checked against a local decoder model or a
// result written out in the table. Both channels idle at random; the
// receiver holds off long so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // where the local decoder stands within a buffer
   typedef enum logic [1:0] {
      SCAN_MARK,
      SCAN_UTF8,
      SCAN_LE,
      SCAN_BE
   } scan_phase_type;

   // one directed row; typed > 0 means the expected results are written out
   typedef struct {
      logic [7:0]               data;
      logic                     last;
      int                       typed;
      bsd_pkg::rsp_payload_type first_exp;
      bsd_pkg::rsp_payload_type second_exp;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid;
   logic                     req_stall;
   bsd_pkg::req_payload_type req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   bsd_pkg::rsp_payload_type rsp_payload;
   logic                     csr_wr_en;
   logic                     csr_wr_data;

   // local decoder state, with its own copy of the host order register
   logic           host_le;
   scan_phase_type scan_phase;
   logic [7:0]     held [3];
   int             held_n;
   logic [7:0]     low_byte;
   logic           low_ok;
   int             seq_left;
   logic [15:0]    acc;
   logic           halted;

   bsd_pkg::rsp_payload_type step_units[$];      // results of the byte just decoded
   bsd_pkg::rsp_payload_type expected_units[$];  // results still owed by the block
   stim_row_type             stim_table[$];
   logic [7:0]               raw_bytes[$];       // random buffer under construction

   int mismatch_count = 0;
   int req_sent = 0;
   bit req_calm = 1'b0;
   bit squeeze_req = 1'b0;

   bom_sniffing_text_decoder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Local decoder
   // ------------------------------------------------------------------------

   // encoding as reported: the mark fixes the order, the register the label
   function automatic logic [1:0] reported_enc();
      logic [1:0] enc;
      case (scan_phase)
         SCAN_LE: enc = host_le ? bsd_pkg::ENC_NATIVE : bsd_pkg::ENC_SWAPPED;
         SCAN_BE: enc = host_le ? bsd_pkg::ENC_SWAPPED : bsd_pkg::ENC_NATIVE;
         default: enc = bsd_pkg::ENC_UTF8;
      endcase
      return enc;
   endfunction

   function automatic void restart_scan();
      scan_phase = SCAN_MARK;
      held[0]    = 8'h00;
      held[1]    = 8'h00;
      held[2]    = 8'h00;
      held_n     = 0;
      low_byte   = 8'h00;
      low_ok     = 1'b0;
      seq_left   = 0;
      acc        = 16'h0000;
      halted     = 1'b0;
   endfunction

   // one byte never gives more than four result transactions
   function automatic void emit(logic [15:0] unit, logic has_unit, logic eot, logic cut);
      bsd_pkg::rsp_payload_type r;
      r.code_unit   = unit;
      r.unit_valid  = has_unit;
      r.end_of_text = eot;
      r.encoding    = reported_enc();
      r.truncated   = cut;
      if (step_units.size() < 4)
         step_units.insert(step_units.size(), r);
   endfunction

   // a zero unit silences the rest of a UTF-8 buffer
   function automatic void emit_char(logic [15:0] unit);
      emit(unit, 1'b1, 1'b0, 1'b0);
      if (unit == 16'h0000)
         halted = 1'b1;
   endfunction

   function automatic void feed_utf8(logic [7:0] b);
      if (halted) begin
         // output has stopped until the buffer ends
      end else if (seq_left > 0) begin
         // low six bits are taken whether or not the byte is 10xxxxxx
         acc = {acc[9:0], b[5:0]};
         seq_left--;
         if (seq_left == 0)
            emit_char(acc);
      end else if ((b & bsd_pkg::ASCII_MASK) == 8'h00) begin
         emit_char({8'h00, b});
      end else if ((b & bsd_pkg::LEAD2_MASK) == bsd_pkg::LEAD2_PAT) begin
         acc      = {11'd0, b[4:0]};
         seq_left = 1;
      end else if ((b & bsd_pkg::LEAD3_MASK) == bsd_pkg::LEAD3_PAT) begin
         acc      = {12'd0, b[3:0]};
         seq_left = 2;
      end else if ((b & bsd_pkg::LEAD4_MASK) == bsd_pkg::LEAD4_PAT) begin
         acc      = {13'd0, b[2:0]};
         seq_left = 3;
      end else if ((b & bsd_pkg::LEAD5_MASK) == bsd_pkg::LEAD5_PAT) begin
         acc      = {14'd0, b[1:0]};
         seq_left = 4;
      end else if ((b & bsd_pkg::LEAD6_MASK) == bsd_pkg::LEAD6_PAT) begin
         acc      = {15'd0, b[0]};
         seq_left = 5;
      end else begin
         // stray continuation, FE or FF as lead
         emit_char(16'h0000);
      end
   endfunction

   // no mark after all: the held bytes are text
   function automatic void replay_held();
      scan_phase = SCAN_UTF8;
      for (int i = 0; i < held_n; i++)
         feed_utf8(held[i]);
      held_n = 0;
   endfunction

   function automatic void decode_byte(bsd_pkg::req_payload_type item);
      logic [7:0] b;
      b = item.data_byte;
      step_units.delete();
      case (scan_phase)
         SCAN_MARK: begin
            held[held_n] = b;
            held_n++;
            if (held_n == 1) begin
               if (item.last_byte)
                  replay_held();
            end else if (held_n == 2) begin
               if (held[0] == bsd_pkg::BOM_FF && held[1] == bsd_pkg::BOM_FE) begin
                  scan_phase = SCAN_LE;
                  held_n     = 0;
               end else if (held[0] == bsd_pkg::BOM_FE && held[1] == bsd_pkg::BOM_FF) begin
                  scan_phase = SCAN_BE;
                  held_n     = 0;
               end else if (!(held[0] == bsd_pkg::BOM_EF && held[1] == bsd_pkg::BOM_BB)
                            || item.last_byte) begin
                  replay_held();
               end
            end else begin
               if (b == bsd_pkg::BOM_BF) begin
                  scan_phase = SCAN_UTF8;
                  held_n     = 0;
               end else begin
                  replay_held();
               end
            end
         end
         SCAN_UTF8: feed_utf8(b);
         default: begin
            if (low_ok) begin
               emit(scan_phase == SCAN_LE ? {b, low_byte} : {low_byte, b},
                    1'b1, 1'b0, 1'b0);
               low_ok = 1'b0;
            end else begin
               low_byte = b;
               low_ok   = 1'b1;
            end
         end
      endcase
      if (item.last_byte) begin
         emit(16'h0000, 1'b0, 1'b1, scan_phase == SCAN_UTF8 && seq_left > 0 && !halted);
         restart_scan();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic bsd_pkg::rsp_payload_type utf8_result(logic [15:0] unit, logic eot,
                                                            logic cut);
      bsd_pkg::rsp_payload_type r;
      r.code_unit   = unit;
      r.unit_valid  = !eot;
      r.end_of_text = eot;
      r.encoding    = bsd_pkg::ENC_UTF8;
      r.truncated   = cut;
      return r;
   endfunction

   function automatic void add_row(logic [7:0] data, logic last, int typed,
                                   bsd_pkg::rsp_payload_type first_exp,
                                   bsd_pkg::rsp_payload_type second_exp);
      stim_row_type row;
      row.data       = data;
      row.last       = last;
      row.typed      = typed;
      row.first_exp  = first_exp;
      row.second_exp = second_exp;
      stim_table.insert(stim_table.size(), row);
   endfunction

   // appends one byte to the random buffer
   function automatic void add_byte(logic [7:0] v);
      raw_bytes.insert(raw_bytes.size(), v);
   endfunction

   // one character, mostly well formed; the odd continuation is random
   function automatic void add_char();
      int         pick;
      int         len;
      logic [7:0] lead;
      pick = $urandom_range(0, 15);
      len  = pick < 7 ? 1 : pick < 10 ? 2 : pick < 13 ? 3 : pick < 14 ? 4 : pick < 15 ? 5 : 6;
      case (len)
         1:       lead = 8'($urandom_range(1, 127));
         2:       lead = {3'b110, 5'($urandom)};
         3:       lead = {4'b1110, 4'($urandom)};
         4:       lead = {5'b11110, 3'($urandom)};
         5:       lead = {6'b111110, 2'($urandom)};
         default: lead = {7'b1111110, 1'($urandom)};
      endcase
      add_byte(lead);
      repeat (len - 1)
         add_byte($urandom_range(0, 15) == 0 ? 8'($urandom) : {2'b10, 6'($urandom)});
   endfunction

   function automatic void build_buffer();
      int kind;
      int n;
      raw_bytes.delete();
      kind = $urandom_range(0, 9);
      case (kind)
         4, 5: begin
            // UTF-16, either mark, odd lengths included, zero bytes common
            if ($urandom_range(0, 1)) begin
               add_byte(bsd_pkg::BOM_FF);
               add_byte(bsd_pkg::BOM_FE);
            end else begin
               add_byte(bsd_pkg::BOM_FE);
               add_byte(bsd_pkg::BOM_FF);
            end
            n = $urandom_range(0, 12);
            repeat (n)
               add_byte($urandom_range(0, 7) == 0 ? 8'h00 : 8'($urandom));
         end
         6: begin
            // short buffers and near-marks
            case ($urandom_range(0, 4))
               0: add_byte(8'($urandom));
               1: begin
                  add_byte(bsd_pkg::BOM_EF);
                  add_byte(bsd_pkg::BOM_BB);
               end
               2: begin
                  add_byte(bsd_pkg::BOM_EF);
                  add_byte(bsd_pkg::BOM_BB);
                  add_byte(8'($urandom));
               end
               3: begin
                  add_byte(bsd_pkg::BOM_EF);
                  add_byte(8'($urandom));
               end
               default: begin
                  add_byte($urandom_range(0, 1) ? bsd_pkg::BOM_FF : bsd_pkg::BOM_FE);
                  add_byte($urandom_range(0, 1) ? bsd_pkg::BOM_FE : bsd_pkg::BOM_FF);
               end
            endcase
         end
         7: begin
            n = $urandom_range(1, 10);
            repeat (n)
               add_byte(8'($urandom));
         end
         default: begin
            // UTF-8, with the mark in kinds 0 to 3
            if (kind < 4) begin
               add_byte(bsd_pkg::BOM_EF);
               add_byte(bsd_pkg::BOM_BB);
               add_byte(bsd_pkg::BOM_BF);
            end
            n = $urandom_range(1, 8);
            repeat (n)
               add_char();
            // now and then cut the tail off mid character
            if ($urandom_range(0, 3) == 0) begin
               n = $urandom_range(1, 3);
               repeat (n)
                  if (raw_bytes.size() > 1)
                     void'(raw_bytes.pop_back());
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------

   // offers one byte after a random gap and returns at the accepting edge
   task automatic send_byte(input bsd_pkg::req_payload_type item);
      int gap;
      if (req_sent % 32 == 0)
         req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 7);
      req_sent++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // the register may only change once all owed results are back
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_units.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_host_order(input logic value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      host_le = value;
   endtask

   // random buffers until quota bytes have been decoded; bytes swallowed
   // after a zero unit are not counted
   task automatic run_random_phase(input int quota);
      int                       sent_here;
      bit                       squeezed;
      bit                       dull;
      bsd_pkg::req_payload_type item;
      sent_here = 0;
      squeezed  = 1'b0;
      while (sent_here < quota) begin
         build_buffer();
         foreach (raw_bytes[i]) begin
            if (sent_here >= 40 && !squeezed) begin
               squeeze_req = 1'b1;
               squeezed    = 1'b1;
            end
            item.data_byte = raw_bytes[i];
            item.last_byte = (i == raw_bytes.size() - 1);
            send_byte(item);
            dull = (scan_phase == SCAN_UTF8) && halted && !item.last_byte;
            decode_byte(item);
            foreach (step_units[k])
               expected_units.insert(expected_units.size(), step_units[k]);
            if (!dull)
               sent_here++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      bsd_pkg::req_payload_type item;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      host_le     = 1'b1;
      restart_scan();

      // directed table; single-byte buffers carry their results written out
      add_row(8'h41, 1'b1, 2, utf8_result(16'h0041, 1'b0, 1'b0),
              utf8_result(16'h0000, 1'b1, 1'b0));
      // lead byte cut off by the end of the buffer
      add_row(8'hC3, 1'b1, 1, utf8_result(16'h0000, 1'b1, 1'b1), '0);
      // FE as a lead byte gives a zero unit
      add_row(8'hFE, 1'b1, 2, utf8_result(16'h0000, 1'b0, 1'b0),
              utf8_result(16'h0000, 1'b1, 1'b0));
      // buffer ending on the first two bytes of the UTF-8 mark
      add_row(8'hEF, 1'b0, 0, '0, '0);
      add_row(8'hBB, 1'b1, 0, '0, '0);
      // little-endian mark, a zero unit that does not stop, odd tail byte
      add_row(8'hFF, 1'b0, 0, '0, '0);
      add_row(8'hFE, 1'b0, 0, '0, '0);
      add_row(8'h00, 1'b0, 0, '0, '0);
      add_row(8'h00, 1'b0, 0, '0, '0);
      add_row(8'h7A, 1'b1, 0, '0, '0);
      // big-endian mark
      add_row(8'hFE, 1'b0, 0, '0, '0);
      add_row(8'hFF, 1'b0, 0, '0, '0);
      add_row(8'h12, 1'b0, 0, '0, '0);
      add_row(8'h34, 1'b1, 0, '0, '0);
      // UTF-8 mark, six-byte lead with a malformed follower, then a stray
      add_row(8'hEF, 1'b0, 0, '0, '0);
      add_row(8'hBB, 1'b0, 0, '0, '0);
      add_row(8'hBF, 1'b0, 0, '0, '0);
      add_row(8'hFD, 1'b0, 0, '0, '0);
      add_row(8'h3F, 1'b0, 0, '0, '0);
      add_row(8'hBF, 1'b0, 0, '0, '0);
      add_row(8'hBF, 1'b0, 0, '0, '0);
      add_row(8'hBF, 1'b0, 0, '0, '0);
      add_row(8'hBF, 1'b0, 0, '0, '0);
      add_row(8'h80, 1'b1, 0, '0, '0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_host_order(1'b1);

      foreach (stim_table[i]) begin
         item.data_byte = stim_table[i].data;
         item.last_byte = stim_table[i].last;
         send_byte(item);
         // model still steps on typed rows to keep its state in line
         decode_byte(item);
         if (stim_table[i].typed == 0) begin
            foreach (step_units[k])
               expected_units.insert(expected_units.size(), step_units[k]);
         end else begin
            expected_units.insert(expected_units.size(), stim_table[i].first_exp);
            if (stim_table[i].typed > 1)
               expected_units.insert(expected_units.size(), stim_table[i].second_exp);
         end
      end

      // random buffers under both host orders
      wait_idle();
      write_host_order(1'b0);
      run_random_phase(145);
      wait_idle();
      write_host_order(1'b1);
      run_random_phase(145);
      wait_idle();
      write_host_order(1'b0);
      run_random_phase(145);
      wait_idle();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus a long hold-off on request so that the
   // internal queue fills and the block stalls its input
   // ------------------------------------------------------------------------
   initial begin : drain_side
      int gap;
      int taken;
      bit calm;
      rsp_stall = 1'b0;
      taken     = 0;
      calm      = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
         end
         if (taken % 32 == 0)
            calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // ------------------------------------------------------------------------
   // Checker: each accepted result against the oldest owed one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : unit_check
      bsd_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_units.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected result transaction: unit %h valid %b end %b enc %0d trunc %b",
                        $time, rsp_payload.code_unit, rsp_payload.unit_valid,
                        rsp_payload.end_of_text, rsp_payload.encoding, rsp_payload.truncated);
            mismatch_count++;
         end else begin
            want = expected_units.pop_front();
            if (rsp_payload.code_unit   !== want.code_unit   ||
                rsp_payload.unit_valid  !== want.unit_valid  ||
                rsp_payload.end_of_text !== want.end_of_text ||
                rsp_payload.encoding    !== want.encoding    ||
                rsp_payload.truncated   !== want.truncated) begin
               if (mismatch_count < 10) begin
                  $display("%0t: result mismatch", $time);
                  $display("   expected unit %h valid %b end %b enc %0d trunc %b",
                           want.code_unit, want.unit_valid, want.end_of_text,
                           want.encoding, want.truncated);
                  $display("   actual   unit %h valid %b end %b enc %0d trunc %b",
                           rsp_payload.code_unit, rsp_payload.unit_valid,
                           rsp_payload.end_of_text, rsp_payload.encoding,
                           rsp_payload.truncated);
               end
               mismatch_count++;
            end
         end
      end
   end

   // hard stop, far beyond the slowest legal run
   initial begin : watchdog
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[files.f]
src/bsd_pkg.sv
src/bsd_fifo.sv
src/bsd_front.sv
src/bsd_back.sv
src/bom_sniffing_text_decoder.sv
verif/tb.sv
